// ----- hw/rtl/rgx_pkg.sv -----
// ----------------------------------------------------------------------------
// rgx_pkg: shared types and constants
// Register codes, reset values, matrix constants and the queue entry type
// for the RGB to xy gamut clamp unit.
// ----------------------------------------------------------------------------
package rgx_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int CHROMA_W          = 16;
	localparam int QUEUE_DEPTH       = 4;
	localparam int CFG_IDX_W         = 3;

	// register index codes
	localparam logic [CFG_IDX_W-1:0] REG_RED_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_Y  = 3'd5;

	localparam logic [CHROMA_W-1:0] RST_RED_X   = 16'd44171;
	localparam logic [CHROMA_W-1:0] RST_RED_Y   = 16'd21103;
	localparam logic [CHROMA_W-1:0] RST_GREEN_X = 16'd26739;
	localparam logic [CHROMA_W-1:0] RST_GREEN_Y = 16'd33882;
	localparam logic [CHROMA_W-1:0] RST_BLUE_X  = 16'd11010;
	localparam logic [CHROMA_W-1:0] RST_BLUE_Y  = 16'd2687;

	// wide-gamut D65 matrix, in millionths
	localparam int K_XR = 649926;
	localparam int K_XG = 103455;
	localparam int K_XB = 197109;
	localparam int K_YR = 234327;
	localparam int K_YG = 743075;
	localparam int K_YB = 22598;
	localparam int K_ZG = 53077;
	localparam int K_ZB = 1035763;

	typedef struct packed {
		logic [CHROMA_W-1:0] rx;
		logic [CHROMA_W-1:0] ry;
		logic [CHROMA_W-1:0] gx;
		logic [CHROMA_W-1:0] gy;
		logic [CHROMA_W-1:0] bx;
		logic [CHROMA_W-1:0] by;
	} vtx_t;

	typedef struct packed {
		logic [CHROMA_W-1:0] x;
		logic [CHROMA_W-1:0] y;
	} xy_t;

endpackage

// ----- hw/rtl/rgx_if.sv -----
// ----------------------------------------------------------------------------
// rgx_if: channel interfaces
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface rgx_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	modport source (output valid, red_level, green_level, blue_level, input ready);
	modport sink (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface rgx_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] chroma_x;
	logic [15:0] chroma_y;
	logic        was_clamped;
	modport source (output valid, chroma_x, chroma_y, was_clamped, input ready);
	modport sink (input valid, chroma_x, chroma_y, was_clamped, output ready);
endinterface

interface rgx_cfg_if import rgx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CHROMA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rgx_div.sv -----
// ----------------------------------------------------------------------------
// rgx_div: pipelined restoring divider
// LANES parallel quotients, one quotient bit per stage, QW stages. The
// numerator's top NW-QW bits must be below the divisor.
// ----------------------------------------------------------------------------
module rgx_div #(
	parameter int LANES = 1,
	parameter int NW    = 8,
	parameter int DW    = 8,
	parameter int QW    = 4,
	parameter int SBW   = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  in_num [LANES],
	input  logic [DW-1:0]  in_den [LANES],
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [QW-1:0]  out_quo [LANES],
	output logic [SBW-1:0] out_sb
);

	logic [QW:0]    vld_s;
	logic [DW-1:0]  rem_s [QW+1][LANES];
	logic [QW-1:0]  low_s [QW+1][LANES];
	logic [DW-1:0]  den_s [QW+1][LANES];
	logic [SBW-1:0] sb_s  [QW+1];

	assign vld_s[0] = in_valid;
	assign sb_s[0]  = in_sb;

	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign rem_s[0][l] = DW'(in_num[l][NW-1:QW]);
		assign low_s[0][l] = in_num[l][QW-1:0];
		assign den_s[0][l] = in_den[l];
		assign out_quo[l]  = low_s[QW][l];
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_s[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] trial;
			logic        ge;
			assign trial = {rem_s[k][l], low_s[k][l][QW-1]};
			assign ge    = trial >= {1'b0, den_s[k][l]};

			// quotient bits shift in behind the consumed numerator bits
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? DW'(trial - {1'b0, den_s[k][l]}) : trial[DW-1:0];
					low_s[k+1][l] <= {low_s[k][l][QW-2:0], ge};
					den_s[k+1][l] <= den_s[k][l];
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_sb    = sb_s[QW];

endmodule

// ----- hw/rtl/rgx_front.sv -----
// ----------------------------------------------------------------------------
// rgx_front: linearize, matrix and chromaticity divide
// Gamma table lookup, RGB to XYZ matrix, then x = X/S and y = Y/S through
// a pipelined divider. Saturated Q0.16 xy goes to the queue.
// ----------------------------------------------------------------------------
module rgx_front import rgx_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	rgx_pix_if.sink pix,
	output logic   out_valid,
	input  logic   out_ready,
	output xy_t    out_data
);

	localparam int F  = FRACTION_BITS;
	localparam int LW = F + 1;
	localparam int CW = F + 1;
	localparam int PW = 2 * F + 2;
	localparam int AW = 2 * F + 3;
	localparam int XW = F + 2;
	localparam int SW = F + 3;
	localparam int NW = F + CHROMA_W + 3;
	localparam int QW = CHROMA_W + 1;

	localparam logic [CW-1:0] C_XR = CW'(((64'(K_XR) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_XG = CW'(((64'(K_XG) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_XB = CW'(((64'(K_XB) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_YR = CW'(((64'(K_YR) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_YG = CW'(((64'(K_YG) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_YB = CW'(((64'(K_YB) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_ZG = CW'(((64'(K_ZG) << F) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_ZB = CW'(((64'(K_ZB) << F) + 64'd500000) / 64'd1000000);
	localparam logic [AW-1:0] RND  = AW'(64'd1 << (F - 1));

	typedef logic [LW-1:0] lin_rom_t [256];

	function automatic longint unsigned m31(input longint unsigned a,
			input longint unsigned b);
		return (a * b + 64'h4000_0000) >> 31;
	endfunction

	// sRGB curve: linear segment for low codes, Q0.31 fifth root above
	function automatic lin_rom_t build_lin_rom();
		lin_rom_t          rom;
		longint unsigned   v, v2, lo, hi, mid, y2, y4, p5, l;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				rom[c] = LW'((64'(c) * 64'd100 * (64'd1 << F) + 64'd164730) / 64'd329460);
			end else begin
				v  = ((64'd1000 * 64'(c) + 64'd14025) << 31) / 64'd269025;
				v2 = m31(v, v);
				lo = 64'd0;
				hi = 64'd1 << 31;
				for (int k = 0; k < 33; k++) begin
					if (lo < hi) begin
						mid = lo + (hi - lo + 64'd1) / 2;
						y2  = m31(mid, mid);
						y4  = m31(y2, y2);
						p5  = m31(y4, mid);
						if (p5 <= v2) lo = mid;
						else hi = mid - 64'd1;
					end
				end
				l      = m31(v2, lo);
				rom[c] = LW'((l + (64'd1 << (30 - F))) >> (31 - F));
			end
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [LW-1:0] lr_s1, lg_s1, lb_s1;
	logic [PW-1:0] pxr_s2, pxg_s2, pxb_s2, pyr_s2, pyg_s2, pyb_s2, pzg_s2, pzb_s2;
	logic [XW-1:0] cx_s3, cy_s3, cz_s3;
	logic [SW-1:0] sum;
	logic [NW-1:0] numx_s4, numy_s4;
	logic [SW-1:0] den_s4;
	logic          zero_s4;
	logic [NW-1:0] div_num [2];
	logic [SW-1:0] div_den [2];
	logic [QW-1:0] div_quo [2];
	logic [0:0]    div_zero;
	logic          div_valid;

	assign en        = !div_valid || out_ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign sum = SW'(cx_s3) + SW'(cy_s3) + SW'(cz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			lr_s1   <= LIN_ROM[pix.red_level];
			lg_s1   <= LIN_ROM[pix.green_level];
			lb_s1   <= LIN_ROM[pix.blue_level];

			pxr_s2  <= PW'(lr_s1) * PW'(C_XR);
			pxg_s2  <= PW'(lg_s1) * PW'(C_XG);
			pxb_s2  <= PW'(lb_s1) * PW'(C_XB);
			pyr_s2  <= PW'(lr_s1) * PW'(C_YR);
			pyg_s2  <= PW'(lg_s1) * PW'(C_YG);
			pyb_s2  <= PW'(lb_s1) * PW'(C_YB);
			pzg_s2  <= PW'(lg_s1) * PW'(C_ZG);
			pzb_s2  <= PW'(lb_s1) * PW'(C_ZB);

			cx_s3   <= XW'((AW'(pxr_s2) + AW'(pxg_s2) + AW'(pxb_s2) + RND) >> F);
			cy_s3   <= XW'((AW'(pyr_s2) + AW'(pyg_s2) + AW'(pyb_s2) + RND) >> F);
			cz_s3   <= XW'((AW'(pzg_s2) + AW'(pzb_s2) + RND) >> F);

			// round to nearest: add S/2 before dividing
			numx_s4 <= (NW'(cx_s3) << CHROMA_W) + NW'(sum >> 1);
			numy_s4 <= (NW'(cy_s3) << CHROMA_W) + NW'(sum >> 1);
			den_s4  <= sum;
			zero_s4 <= sum == '0;
		end
	end

	assign div_num[0] = numx_s4;
	assign div_num[1] = numy_s4;
	assign div_den[0] = den_s4;
	assign div_den[1] = den_s4;

	rgx_div #(
		.LANES (2),
		.NW    (NW),
		.DW    (SW),
		.QW    (QW),
		.SBW   (1)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.in_num    (div_num),
		.in_den    (div_den),
		.in_sb     (zero_s4),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_sb    (div_zero)
	);

	assign out_valid = div_valid;

	always_comb begin
		out_data.x = div_quo[0][QW-1] ? '1 : div_quo[0][CHROMA_W-1:0];
		out_data.y = div_quo[1][QW-1] ? '1 : div_quo[1][CHROMA_W-1:0];
		if (div_zero[0]) begin
			out_data = '0;
		end
	end

endmodule

// ----- hw/rtl/rgx_fifo.sv -----
// ----------------------------------------------------------------------------
// rgx_fifo: front to back queue
// Small register queue of xy points; decouples the two pipelines.
// ----------------------------------------------------------------------------
module rgx_fifo import rgx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  xy_t  push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output xy_t  pop_data
);

	localparam int PTW = $clog2(QUEUE_DEPTH);
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	xy_t            mem_q [QUEUE_DEPTH];
	logic [PTW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] count_q;
	logic           push, pop;

	assign push_ready = count_q != CNW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == CNW'($past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

	a_pass_data: assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == '0) |=> (pop_valid && pop_data == $past(push_data)))
		else $error("queue head differs from transaction written into empty queue");
`endif

endmodule

// ----- hw/rtl/rgx_back.sv -----
// ----------------------------------------------------------------------------
// rgx_back: gamut triangle test and edge clamp
// Barycentric inside test, projection onto each triangle edge through a
// pipelined divider, nearest projection by squared distance.
// ----------------------------------------------------------------------------
module rgx_back import rgx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  vtx_t vtx,
	input  logic in_valid,
	output logic in_ready,
	input  xy_t  in_data,
	rgx_res_if.source res
);

	localparam int NE  = 3;
	localparam int DNW = 50;
	localparam int DDW = 34;
	localparam int DQW = CHROMA_W;

	localparam logic [1:0] PROJ_START = 2'd0;
	localparam logic [1:0] PROJ_END   = 2'd1;
	localparam logic [1:0] PROJ_MID   = 2'd2;

	typedef struct packed {
		logic [CHROMA_W-1:0] px;
		logic [CHROMA_W-1:0] py;
		logic                in_tri;
		logic [NE-1:0][1:0]  pcase;
	} bsb_t;

	logic en;

	// vertex geometry; edges in order ab (red-green), ac (blue-red), bc (green-blue)
	logic signed [16:0] rvx, rvy, gvx, gvy, bvx, bvy;
	logic signed [16:0] v1x, v1y, v2x, v2y;
	logic signed [16:0] ax [NE], ay [NE], bx [NE], by [NE], ex [NE], ey [NE];

	always_comb begin
		rvx = $signed({1'b0, vtx.rx});
		rvy = $signed({1'b0, vtx.ry});
		gvx = $signed({1'b0, vtx.gx});
		gvy = $signed({1'b0, vtx.gy});
		bvx = $signed({1'b0, vtx.bx});
		bvy = $signed({1'b0, vtx.by});
		v1x = gvx - rvx;
		v1y = gvy - rvy;
		v2x = bvx - rvx;
		v2y = bvy - rvy;
		ax[0] = rvx; ay[0] = rvy; bx[0] = gvx; by[0] = gvy;
		ax[1] = bvx; ay[1] = bvy; bx[1] = rvx; by[1] = rvy;
		ax[2] = gvx; ay[2] = gvy; bx[2] = bvx; by[2] = bvy;
		for (int e = 0; e < NE; e++) begin
			ex[e] = bx[e] - ax[e];
			ey[e] = by[e] - ay[e];
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic div_valid;

	assign en       = !vld_s9 || res.ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= div_valid;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// stage 1: differences
	logic [CHROMA_W-1:0] px_s1, py_s1;
	logic signed [16:0]  qx_s1, qy_s1;
	logic signed [16:0]  wx_s1 [NE], wy_s1 [NE];
	logic signed [16:0]  pxs, pys;

	assign pxs = $signed({1'b0, in_data.x});
	assign pys = $signed({1'b0, in_data.y});

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_data.x;
			py_s1 <= in_data.y;
			qx_s1 <= pxs - rvx;
			qy_s1 <= pys - rvy;
			for (int e = 0; e < NE; e++) begin
				wx_s1[e] <= pxs - ax[e];
				wy_s1[e] <= pys - ay[e];
			end
		end
	end

	// stage 2: products
	logic [CHROMA_W-1:0] px_s2, py_s2;
	logic signed [33:0]  sa_s2, sb_s2, ta_s2, tb_s2, da_s2, db_s2;
	logic signed [33:0]  na_s2 [NE], nb_s2 [NE], ea_s2 [NE], eb_s2 [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			sa_s2 <= qx_s1 * v2y;
			sb_s2 <= qy_s1 * v2x;
			ta_s2 <= v1x * qy_s1;
			tb_s2 <= v1y * qx_s1;
			da_s2 <= v1x * v2y;
			db_s2 <= v1y * v2x;
			for (int e = 0; e < NE; e++) begin
				na_s2[e] <= wx_s1[e] * ex[e];
				nb_s2[e] <= wy_s1[e] * ey[e];
				ea_s2[e] <= ex[e] * ex[e];
				eb_s2[e] <= ey[e] * ey[e];
			end
		end
	end

	// stage 3: cross products, projection numerators and squared edge lengths
	logic [CHROMA_W-1:0] px_s3, py_s3;
	logic signed [34:0]  s_s3, t_s3, d_s3;
	logic signed [34:0]  num_s3 [NE];
	logic [DDW-1:0]      den_s3 [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			s_s3  <= 35'(sa_s2) - 35'(sb_s2);
			t_s3  <= 35'(ta_s2) - 35'(tb_s2);
			d_s3  <= 35'(da_s2) - 35'(db_s2);
			for (int e = 0; e < NE; e++) begin
				num_s3[e] <= 35'(na_s2[e]) + 35'(nb_s2[e]);
				den_s3[e] <= {1'b0, ea_s2[e][32:0]} + {1'b0, eb_s2[e][32:0]};
			end
		end
	end

	// stage 4: inside test and projection case per edge
	logic signed [34:0] sn, tn, dn;
	logic signed [35:0] st;
	logic               inside_c;
	logic [1:0]         pc_c [NE];

	always_comb begin
		if (d_s3 < 0) begin
			sn = -s_s3;
			tn = -t_s3;
			dn = -d_s3;
		end else begin
			sn = s_s3;
			tn = t_s3;
			dn = d_s3;
		end
		st       = 36'(sn) + 36'(tn);
		inside_c = (dn != 0) && !sn[34] && !tn[34] && (st <= 36'(dn));
		for (int e = 0; e < NE; e++) begin
			if (den_s3[e] == '0 || num_s3[e] <= 0) begin
				pc_c[e] = PROJ_START;
			end else if (num_s3[e] >= $signed({1'b0, den_s3[e]})) begin
				pc_c[e] = PROJ_END;
			end else begin
				pc_c[e] = PROJ_MID;
			end
		end
	end

	logic [CHROMA_W-1:0] px_s4, py_s4;
	logic                inside_s4;
	logic [1:0]          pc_s4 [NE];
	logic [32:0]         numc_s4 [NE];
	logic [DDW-1:0]      den_s4 [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4     <= px_s3;
			py_s4     <= py_s3;
			inside_s4 <= inside_c;
			for (int e = 0; e < NE; e++) begin
				pc_s4[e]   <= pc_c[e];
				numc_s4[e] <= num_s3[e][32:0];
				den_s4[e]  <= den_s3[e];
			end
		end
	end

	// stage 5: |e| * num
	logic [CHROMA_W-1:0] px_s5, py_s5;
	logic                inside_s5;
	logic [1:0]          pc_s5 [NE];
	logic [DDW-1:0]      den_s5 [NE];
	logic [48:0]         mgx_s5 [NE], mgy_s5 [NE];
	logic signed [16:0]  exa [NE], eya [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			exa[e] = ex[e][16] ? -ex[e] : ex[e];
			eya[e] = ey[e][16] ? -ey[e] : ey[e];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5     <= px_s4;
			py_s5     <= py_s4;
			inside_s5 <= inside_s4;
			for (int e = 0; e < NE; e++) begin
				pc_s5[e]  <= pc_s4[e];
				den_s5[e] <= den_s4[e];
				mgx_s5[e] <= 49'(exa[e][15:0]) * 49'(numc_s4[e]);
				mgy_s5[e] <= 49'(eya[e][15:0]) * 49'(numc_s4[e]);
			end
		end
	end

	// stage 6: rounding offset, divider operands
	logic [DNW-1:0] dnum_s6 [2*NE];
	logic [DDW-1:0] dden_s6 [2*NE];
	bsb_t           sb_s6;
	bsb_t           sb_d;
	logic [DQW-1:0] quo [2*NE];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6.px     <= px_s5;
			sb_s6.py     <= py_s5;
			sb_s6.in_tri <= inside_s5;
			for (int e = 0; e < NE; e++) begin
				sb_s6.pcase[e]   <= pc_s5[e];
				dnum_s6[2*e]     <= DNW'(mgx_s5[e]) + DNW'(den_s5[e] >> 1);
				dnum_s6[2*e + 1] <= DNW'(mgy_s5[e]) + DNW'(den_s5[e] >> 1);
				dden_s6[2*e]     <= den_s5[e];
				dden_s6[2*e + 1] <= den_s5[e];
			end
		end
	end

	rgx_div #(
		.LANES (2 * NE),
		.NW    (DNW),
		.DW    (DDW),
		.QW    (DQW),
		.SBW   ($bits(bsb_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_num    (dnum_s6),
		.in_den    (dden_s6),
		.in_sb     (sb_s6),
		.out_valid (div_valid),
		.out_quo   (quo),
		.out_sb    (sb_d)
	);

	// stage 7: projected points
	logic signed [16:0]  cxc [NE], cyc [NE];
	logic signed [16:0]  qxs, qys;
	logic [CHROMA_W-1:0] px_s7, py_s7;
	logic                inside_s7;
	logic [CHROMA_W-1:0] cx_s7 [NE], cy_s7 [NE];

	always_comb begin
		qxs = '0;
		qys = '0;
		for (int e = 0; e < NE; e++) begin
			qxs = $signed({1'b0, quo[2*e]});
			qys = $signed({1'b0, quo[2*e + 1]});
			case (sb_d.pcase[e])
				PROJ_END: begin
					cxc[e] = bx[e];
					cyc[e] = by[e];
				end
				PROJ_MID: begin
					cxc[e] = ax[e] + (ex[e][16] ? -qxs : qxs);
					cyc[e] = ay[e] + (ey[e][16] ? -qys : qys);
				end
				default: begin
					cxc[e] = ax[e];
					cyc[e] = ay[e];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s7     <= sb_d.px;
			py_s7     <= sb_d.py;
			inside_s7 <= sb_d.in_tri;
			for (int e = 0; e < NE; e++) begin
				cx_s7[e] <= cxc[e][15:0];
				cy_s7[e] <= cyc[e][15:0];
			end
		end
	end

	// stage 8: squared offsets
	logic signed [16:0]  dx [NE], dy [NE];
	logic signed [33:0]  sqx [NE], sqy [NE];
	logic [CHROMA_W-1:0] px_s8, py_s8;
	logic                inside_s8;
	logic [CHROMA_W-1:0] cx_s8 [NE], cy_s8 [NE];
	logic [32:0]         d2x_s8 [NE], d2y_s8 [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			dx[e]  = $signed({1'b0, px_s7}) - $signed({1'b0, cx_s7[e]});
			dy[e]  = $signed({1'b0, py_s7}) - $signed({1'b0, cy_s7[e]});
			sqx[e] = dx[e] * dx[e];
			sqy[e] = dy[e] * dy[e];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s8     <= px_s7;
			py_s8     <= py_s7;
			inside_s8 <= inside_s7;
			for (int e = 0; e < NE; e++) begin
				cx_s8[e]  <= cx_s7[e];
				cy_s8[e]  <= cy_s7[e];
				d2x_s8[e] <= sqx[e][32:0];
				d2y_s8[e] <= sqy[e][32:0];
			end
		end
	end

	// stage 9: nearest edge, earlier edge wins ties
	logic [33:0]         dsq [NE];
	logic [33:0]         best;
	logic [CHROMA_W-1:0] selx, sely;
	logic [CHROMA_W-1:0] ox_s9, oy_s9;
	logic                clamp_s9;

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			dsq[e] = {1'b0, d2x_s8[e]} + {1'b0, d2y_s8[e]};
		end
		best = dsq[0];
		selx = cx_s8[0];
		sely = cy_s8[0];
		for (int e = 1; e < NE; e++) begin
			if (dsq[e] < best) begin
				best = dsq[e];
				selx = cx_s8[e];
				sely = cy_s8[e];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s9    <= inside_s8 ? px_s8 : selx;
			oy_s9    <= inside_s8 ? py_s8 : sely;
			clamp_s9 <= !inside_s8;
		end
	end

	assign res.valid       = vld_s9;
	assign res.chroma_x    = ox_s9;
	assign res.chroma_y    = oy_s9;
	assign res.was_clamped = clamp_s9;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && !res.ready) |=> (vld_s9 && $stable(ox_s9) && $stable(clamp_s9)))
		else $error("result changed while stalled");

	a_inside_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s8 && inside_s8) |=> (!clamp_s9 && ox_s9 == $past(px_s8)))
		else $error("inside point was moved");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && !res.ready) |-> !in_ready)
		else $error("queue popped while output stalled");
`endif

endmodule

// ----- hw/rtl/rgb_to_xy_gamut_clamp_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_xy_gamut_clamp_unit: sRGB pixel to gamut-clamped CIE xy
// Top level: triangle registers, front pipeline, queue, back pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   pix  - one 8-bit RGB pixel per transaction (valid/ready).
//   res  - chroma_x, chroma_y (Q0.16) and was_clamped, one per pixel, in order.
//   cfg  - writes a triangle corner coordinate; index 0..5 is red x/y,
//          green x/y, blue x/y, other indexes are dropped. Always ready.
//          Write only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while res.ready stays high.
// Stages: 47 register stages in all from pixel transaction to result valid,
//   the first loaded at the transaction edge. The front takes 4 stages plus
//   one per quotient bit of the 17-bit xy divider, the queue one, and the
//   back 9 stages plus one per bit of the 16-bit projection divider.
// Reset: pipelines and queue empty, triangle registers at their defaults.
// Stall: a held result freezes the back pipeline; the front takes pixels until
//   the 4-entry queue is full and a front result waits, then pix.ready drops.
// ----------------------------------------------------------------------------
module rgb_to_xy_gamut_clamp_unit import rgx_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rgx_pix_if.sink   pix,
	rgx_res_if.source res,
	rgx_cfg_if.sink   cfg
);

	vtx_t vtx_q;
	logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
	xy_t  q_push_data, q_pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q.rx <= RST_RED_X;
			vtx_q.ry <= RST_RED_Y;
			vtx_q.gx <= RST_GREEN_X;
			vtx_q.gy <= RST_GREEN_Y;
			vtx_q.bx <= RST_BLUE_X;
			vtx_q.by <= RST_BLUE_Y;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RED_X:   vtx_q.rx <= cfg.data;
				REG_RED_Y:   vtx_q.ry <= cfg.data;
				REG_GREEN_X: vtx_q.gx <= cfg.data;
				REG_GREEN_Y: vtx_q.gy <= cfg.data;
				REG_BLUE_X:  vtx_q.bx <= cfg.data;
				REG_BLUE_Y:  vtx_q.by <= cfg.data;
				default: ;
			endcase
		end
	end

	rgx_front #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.out_valid (q_push_valid),
		.out_ready (q_push_ready),
		.out_data  (q_push_data)
	);

	rgx_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	rgx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx      (vtx_q),
		.in_valid (q_pop_valid),
		.in_ready (q_pop_ready),
		.in_data  (q_pop_data),
		.res      (res)
	);

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for rgb_to_xy_gamut_clamp_unit
// Drives pixels and triangle writes, computes the clamped chromaticity of
// each pixel on the side and compares every result in order.
// ----------------------------------------------------------------------------
module tb;
	import rgx_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam int LATENCY = 46;
	localparam longint Q31 = 64'd1 << 31;
	localparam int MAX_CYCLES = 400000;

	typedef struct {
		logic [7:0]  r, g, b;
		bit          known;
		logic [15:0] ex, ey;
		logic        ec;
	} pix_row_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        clamped;
	} chroma_t;

	logic clk;
	logic arst_n;
	rgx_pix_if pix ();
	rgx_res_if res ();
	rgx_cfg_if cfg ();

	rgb_to_xy_gamut_clamp_unit u_top (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .res(res.source), .cfg(cfg.sink)
	);

	vtx_t tri_regs;
	longint lin_lut [256];
	chroma_t chroma_due [$];
	int errors;
	int cycles;
	int hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint mul31(longint a, longint b);
		return (a * b + (Q31 >> 1)) >>> 31;
	endfunction

	function automatic longint pow5(longint y);
		longint y2, y4;
		y2 = mul31(y, y);
		y4 = mul31(y2, y2);
		return mul31(y4, y);
	endfunction

	function automatic longint srgb_linear(longint c);
		longint v, v2, lo, hi, mid;
		if (c <= 10)
			return (c * 100 * (64'd1 << FB) + 164730) / 329460;
		v = ((1000 * c + 14025) << 31) / 269025;
		v2 = mul31(v, v);
		lo = 0;
		hi = Q31;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (pow5(mid) <= v2)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (mul31(v2, lo) + (64'd1 << (30 - FB))) >>> (31 - FB);
	endfunction

	function automatic longint kq(longint micro);
		return ((micro << FB) + 500000) / 1000000;
	endfunction

	function automatic longint rnd_qf(longint acc);
		return (acc + (64'd1 << (FB - 1))) >>> FB;
	endfunction

	function automatic longint div_half_away(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic void edge_snap(longint ax, longint ay, longint bx, longint by,
			longint px, longint py, output longint qx, output longint qy);
		longint ex, ey, num, den;
		ex = bx - ax;
		ey = by - ay;
		num = (px - ax) * ex + (py - ay) * ey;
		den = ex * ex + ey * ey;
		if (den == 0 || num <= 0) begin
			qx = ax;
			qy = ay;
		end else if (num >= den) begin
			qx = bx;
			qy = by;
		end else begin
			qx = ax + div_half_away(ex * num, den);
			qy = ay + div_half_away(ey * num, den);
		end
	endfunction

	function automatic chroma_t clamped_chroma(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		longint r, g, b, cx, cy, cz, sum, ux, uy;
		longint px, py, rx, ry, gx, gy, bx, by;
		longint v1x, v1y, v2x, v2y, s, t, d;
		longint abx, aby, acx, acy, bcx, bcy, best, dd, ox, oy;
		chroma_t o;
		r = lin_lut[r8];
		g = lin_lut[g8];
		b = lin_lut[b8];
		cx = rnd_qf(r * kq(longint'(K_XR)) + g * kq(longint'(K_XG)) + b * kq(longint'(K_XB)));
		cy = rnd_qf(r * kq(longint'(K_YR)) + g * kq(longint'(K_YG)) + b * kq(longint'(K_YB)));
		cz = rnd_qf(g * kq(longint'(K_ZG)) + b * kq(longint'(K_ZB)));
		sum = cx + cy + cz;
		ux = 0;
		uy = 0;
		if (sum != 0) begin
			ux = ((cx << 16) + sum / 2) / sum;
			uy = ((cy << 16) + sum / 2) / sum;
			if (ux > 65535) ux = 65535;
			if (uy > 65535) uy = 65535;
		end
		px = ux; py = uy;
		rx = longint'(tri_regs.rx); ry = longint'(tri_regs.ry);
		gx = longint'(tri_regs.gx); gy = longint'(tri_regs.gy);
		bx = longint'(tri_regs.bx); by = longint'(tri_regs.by);
		v1x = gx - rx; v1y = gy - ry;
		v2x = bx - rx; v2y = by - ry;
		s = (px - rx) * v2y - (py - ry) * v2x;
		t = v1x * (py - ry) - v1y * (px - rx);
		d = v1x * v2y - v1y * v2x;
		if (d < 0) begin
			s = -s; t = -t; d = -d;
		end
		if (d != 0 && s >= 0 && t >= 0 && s + t <= d) begin
			o.x = ux[15:0];
			o.y = uy[15:0];
			o.clamped = 1'b0;
			return o;
		end
		edge_snap(rx, ry, gx, gy, px, py, abx, aby);
		edge_snap(bx, by, rx, ry, px, py, acx, acy);
		edge_snap(gx, gy, bx, by, px, py, bcx, bcy);
		best = (px - abx) ** 2 + (py - aby) ** 2;
		ox = abx; oy = aby;
		dd = (px - acx) ** 2 + (py - acy) ** 2;
		if (dd < best) begin
			best = dd; ox = acx; oy = acy;
		end
		dd = (px - bcx) ** 2 + (py - bcy) ** 2;
		if (dd < best) begin
			ox = bcx; oy = bcy;
		end
		o.x = ox[15:0];
		o.y = oy[15:0];
		o.clamped = 1'b1;
		return o;
	endfunction

	// leaves cfg.valid high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_RED_X:   tri_regs.rx = val;
			REG_RED_Y:   tri_regs.ry = val;
			REG_GREEN_X: tri_regs.gx = val;
			REG_GREEN_Y: tri_regs.gy = val;
			REG_BLUE_X:  tri_regs.bx = val;
			REG_BLUE_Y:  tri_regs.by = val;
			default: ;
		endcase
	endtask

	task automatic load_triangle(vtx_t v);
		write_reg(REG_RED_X, v.rx);
		write_reg(REG_RED_Y, v.ry);
		write_reg(REG_GREEN_X, v.gx);
		write_reg(REG_GREEN_Y, v.gy);
		write_reg(REG_BLUE_X, v.bx);
		write_reg(REG_BLUE_Y, v.by);
	endtask

	task automatic drain();
		while (chroma_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one pixel transaction, after an idle gap given by the caller
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, int gap);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chroma_due.push_back(clamped_chroma(r, g, b));
		pix.valid <= 1'b1;
		pix.red_level <= r;
		pix.green_level <= g;
		pix.blue_level <= b;
		do @(posedge clk); while (!pix.ready);
	endtask

	// result checker
	always @(posedge clk) begin
		chroma_t want;
		if (arst_n && res.valid && res.ready) begin
			if (chroma_due.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d c=%0b", $time,
					res.chroma_x, res.chroma_y, res.was_clamped);
				errors++;
			end else begin
				want = chroma_due.pop_front();
				if (res.chroma_x !== want.x || res.chroma_y !== want.y ||
						res.was_clamped !== want.clamped) begin
					$display("%0t mismatch expected x=%0d y=%0d c=%0b actual x=%0d y=%0d c=%0b",
						$time, want.x, want.y, want.clamped,
						res.chroma_x, res.chroma_y, res.was_clamped);
					errors++;
				end
			end
		end
	end

	// receiver stalls; long hold-off when requested
	initial begin
		int w;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				res.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (w > 0 && $urandom_range(0, 2) != 0) begin
				res.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		pix_row_t rows [$];
		pix_row_t row;
		vtx_t v;
		chroma_t exp_row;
		int gap;
		int burst;
		errors = 0;
		cycles = 0;
		hold_off = 0;
		pix.valid = 1'b0;
		pix.red_level = '0;
		pix.green_level = '0;
		pix.blue_level = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < 256; i++)
			lin_lut[i] = srgb_linear(longint'(i));
		tri_regs = '{RST_RED_X, RST_RED_Y, RST_GREEN_X, RST_GREEN_Y, RST_BLUE_X, RST_BLUE_Y};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: black gives 0,0 (outside default triangle), channel extremes
		rows.push_back('{8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd255, 8'd255, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd255, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd0, 8'd255, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd0, 8'd0, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd10, 8'd10, 8'd10, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd11, 8'd11, 8'd11, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd1, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd170, 8'd85, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0});
		rows.push_back('{8'd0, 8'd128, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0});
		foreach (rows[i]) begin
			row = rows[i];
			send_pixel(row.r, row.g, row.b, 0);
		end
		pix.valid <= 1'b0;
		drain();

		// degenerate triangle: all corners at one point, every pixel lands there
		v = '{16'd30000, 16'd30000, 16'd30000, 16'd30000, 16'd30000, 16'd30000};
		load_triangle(v);
		write_reg(3'd7, 16'hFFFF); // dropped index
		cfg.valid <= 1'b0;
		exp_row = '{16'd30000, 16'd30000, 1'b1};
		chroma_due.push_back(exp_row);
		pix.valid <= 1'b1;
		pix.red_level <= 8'd0;
		pix.green_level <= 8'd0;
		pix.blue_level <= 8'd0;
		do @(posedge clk); while (!pix.ready);
		send_pixel(8'd255, 8'd17, 8'd200, 0);
		pix.valid <= 1'b0;
		drain();

		// extremes: full-range triangle and zero-length edges
		load_triangle('{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0});
		cfg.valid <= 1'b0;
		send_pixel(8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 1);
		send_pixel(8'd0, 8'd0, 8'd255, 0);
		pix.valid <= 1'b0;
		drain();
		load_triangle('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
		cfg.valid <= 1'b0;
		send_pixel(8'd200, 8'd40, 8'd90, 0);
		send_pixel(8'd5, 8'd250, 8'd9, 0);
		pix.valid <= 1'b0;
		drain();

		// random phases with varied triangles
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				v = '{RST_RED_X, RST_RED_Y, RST_GREEN_X, RST_GREEN_Y, RST_BLUE_X, RST_BLUE_Y};
			else if (ph == 1)
				v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
			else begin
				v.rx = 16'($urandom); v.ry = 16'($urandom); v.gx = 16'($urandom);
				v.gy = 16'($urandom); v.bx = 16'($urandom); v.by = 16'($urandom);
			end
			load_triangle(v);
			cfg.valid <= 1'b0;
			if (ph == 3)
				hold_off = 200;
			burst = $urandom_range(0, 1);
			for (int k = 0; k < 50; k++) begin
				if (ph == 3 || (burst && k < 20))
					gap = 0;
				else
					gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gap);
				if (ph == 5 && k == 25) begin
					pix.valid <= 1'b0;
					while (chroma_due.size() != 0)
						@(posedge clk);
				end
			end
			pix.valid <= 1'b0;
			drain();
		end

		if (errors == 0 && chroma_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- rgb_to_xy_gamut_clamp_unit.f -----
hw/rtl/rgx_pkg.sv
hw/rtl/rgx_if.sv
hw/rtl/rgx_div.sv
hw/rtl/rgx_front.sv
hw/rtl/rgx_fifo.sv
hw/rtl/rgx_back.sv
hw/rtl/rgb_to_xy_gamut_clamp_unit.sv
dv/tb.sv
